// ===== hdl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hdl/lcgswr_pkg.sv =====
// -----------------------------------------------------------------------------
// LCG draw package
// Widths, arithmetic constants, register indexes and sequencer states.
// -----------------------------------------------------------------------------
`default_nettype none

package lcgswr_pkg;

  localparam int CNT_W      = 7;
  localparam int DISC_W     = 16;
  localparam int SEED_W     = 27;
  localparam int HALF_W     = 14;
  localparam int OPND_W     = 28;
  localparam int MUL_W      = 2 * OPND_W;
  localparam int QUOT_LSB   = 41;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Generator state is kept as two decimal halves of four digits each.
  localparam int DEC_SPLIT   = 10000;
  localparam int LCG_MULT    = 31415821;
  localparam int LCG_MULT_LO = LCG_MULT % DEC_SPLIT;
  localparam int LCG_MULT_HI = LCG_MULT / DEC_SPLIT;

  // Rounded-up reciprocal: (n * DEC_RECIP) >> QUOT_LSB == n / 10000 for n < 2**27.
  localparam logic [63:0] RECIP_FULL =
      ((64'd1 << QUOT_LSB) + 64'(DEC_SPLIT) - 64'd1) / 64'(DEC_SPLIT);
  localparam logic [OPND_W-1:0] DEC_RECIP = RECIP_FULL[OPND_W-1:0];

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD    = 2'd2;

  localparam logic [CNT_W-1:0]  POOL_SIZE_RST  = 7'd49;
  localparam logic [CNT_W-1:0]  PICK_COUNT_RST = 7'd6;
  localparam logic [DISC_W-1:0] DISCARD_RST    = 16'd900;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEED_DIV,
    ST_SEED_REM,
    ST_SEED_LO,
    ST_FILL,
    ST_LCG_LO,
    ST_LCG_HI,
    ST_LCG_MID,
    ST_LCG_CDIV,
    ST_LCG_CMUL,
    ST_LCG_HDIV,
    ST_LCG_HMUL,
    ST_LCG_DONE,
    ST_PICK_MUL,
    ST_PICK_DIV,
    ST_PICK_RD,
    ST_PICK_EMIT,
    ST_SHIFT_RD,
    ST_SHIFT_WR
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/lcgswr_if.sv =====
// -----------------------------------------------------------------------------
// LCG draw stream interfaces
// Valid/ready channels for request items and drawn numbers.
// -----------------------------------------------------------------------------
`default_nettype none

interface lcgswr_item_if
  import lcgswr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              op;
  logic [SEED_W-1:0] seed_value;

  modport source (output valid, op, seed_value, input ready);
  modport sink   (input valid, op, seed_value, output ready);
endinterface

interface lcgswr_result_if
  import lcgswr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] picked_number;
  logic             last_pick;

  modport source (output valid, picked_number, last_pick, input ready);
  modport sink   (input valid, picked_number, last_pick, output ready);
endinterface

`default_nettype wire

// ===== hdl/lcgswr_ram.sv =====
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module lcgswr_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/lcg_sample_without_replacement_core.sv =====
// -----------------------------------------------------------------------------
// LCG draw without replacement
// Decimal LCG driving distinct draws from a pool of 1..min(pool_size, POOL_MAX).
// -----------------------------------------------------------------------------
// Usage:
//   item_i carries one request per beat: op = 1 loads seed_value into the
//   generator and gives no result; op = 0 draws min(pick_count, pool_size,
//   POOL_MAX) distinct numbers, each a beat on result_o, last_pick on the last.
//   The configuration port writes pool_size, pick_count and discard_steps;
//   write it only while the block is idle.
// Timing:
//   item_i.ready is high only between requests. One shared 28x28 multiplier
//   sets the pace: each generator step needs seven products, issued one per
//   cycle.
// Reset:
//   Generator state clears to zero and registers take 49, 6 and 900. The
//   pool RAM is not cleared; every draw refills it before reading.
// Stall:
//   A result waits in an output register while the block keeps working; the
//   next pick holds until that register is free.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lcg_sample_without_replacement_core
  import lcgswr_pkg::*;
#(
  parameter int POOL_MAX = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  lcgswr_item_if.sink                item_i,
  lcgswr_result_if.source            result_o
);

  localparam int AW      = $clog2(POOL_MAX);
  localparam int CntMax  = (1 << CNT_W) - 1;
  localparam int SizeCap = (POOL_MAX > CntMax) ? CntMax : POOL_MAX;
  localparam int PickW   = HALF_W + CNT_W;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  pool_size_q, pool_size_d;
  logic [CNT_W-1:0]  pick_count_q, pick_count_d;
  logic [DISC_W-1:0] disc_steps_q, disc_steps_d;

  logic [HALF_W-1:0] sh_q, sh_d;
  logic [HALF_W-1:0] sl_q, sl_d;
  logic [SEED_W-1:0] lo_q, lo_d;
  logic [SEED_W-1:0] hi_q, hi_d;
  logic [MUL_W-1:0]  mul_q, mul_d;

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  picks_left_q, picks_left_d;
  logic [DISC_W-1:0] disc_q, disc_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [AW-1:0]     idx_q, idx_d;

  logic              res_valid_q, res_valid_d;
  logic [CNT_W-1:0]  res_num_q, res_num_d;
  logic              res_last_q, res_last_d;

  logic [OPND_W-1:0] mul_a, mul_b;
  logic [HALF_W-1:0] quot_w;
  logic [CNT_W-1:0]  size_w, picks_w, ptr_prev_w;
  logic              accept_w, slot_free_w, emit_w, more_work_w;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CNT_W-1:0]  ram_wdata, ram_rdata;

  lcgswr_ram #(
    .WIDTH (CNT_W),
    .DEPTH (POOL_MAX)
  ) u_pool (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign quot_w      = mul_q[QUOT_LSB +: HALF_W];
  assign mul_d       = mul_a * mul_b;
  assign accept_w    = item_i.valid && item_i.ready;
  assign slot_free_w = !res_valid_q || result_o.ready;
  assign emit_w      = (state_q == ST_PICK_EMIT) && slot_free_w;
  assign more_work_w = (picks_left_q != '0) || (disc_q != '0);
  assign ptr_prev_w  = ptr_q - CNT_W'(1);

  assign size_w  = (pool_size_q > CNT_W'(SizeCap)) ? CNT_W'(SizeCap) : pool_size_q;
  assign picks_w = (pick_count_q > size_w) ? size_w : pick_count_q;

  assign result_o.valid         = res_valid_q;
  assign result_o.picked_number = res_num_q;
  assign result_o.last_pick     = res_last_q;

  // Configuration writes
  always_comb begin
    pool_size_d  = pool_size_q;
    pick_count_d = pick_count_q;
    disc_steps_d = disc_steps_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POOL_SIZE:  pool_size_d  = cfg_wdata_i[CNT_W-1:0];
        REG_PICK_COUNT: pick_count_d = cfg_wdata_i[CNT_W-1:0];
        REG_DISCARD:    disc_steps_d = cfg_wdata_i[DISC_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          state_d = (item_i.op == OP_SEED) ? ST_SEED_DIV : ST_FILL;
        end
      end
      ST_SEED_DIV: state_d = ST_SEED_REM;
      ST_SEED_REM: state_d = ST_SEED_LO;
      ST_SEED_LO:  state_d = ST_IDLE;
      ST_FILL: begin
        if (fill_q == rem_q) begin
          state_d = more_work_w ? ST_LCG_LO : ST_IDLE;
        end
      end
      ST_LCG_LO:   state_d = ST_LCG_HI;
      ST_LCG_HI:   state_d = ST_LCG_MID;
      ST_LCG_MID:  state_d = ST_LCG_CDIV;
      ST_LCG_CDIV: state_d = ST_LCG_CMUL;
      ST_LCG_CMUL: state_d = ST_LCG_HDIV;
      ST_LCG_HDIV: state_d = ST_LCG_HMUL;
      ST_LCG_HMUL: state_d = ST_LCG_DONE;
      ST_LCG_DONE: begin
        // The low product of the next step is already issued here.
        if (picks_left_q != '0) begin
          state_d = ST_PICK_MUL;
        end else if (disc_q == DISC_W'(1)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_LCG_HI;
        end
      end
      ST_PICK_MUL: state_d = ST_PICK_DIV;
      ST_PICK_DIV: state_d = ST_PICK_RD;
      ST_PICK_RD:  state_d = ST_PICK_EMIT;
      ST_PICK_EMIT: begin
        if (slot_free_w) begin
          state_d = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (ptr_q < rem_q) begin
          state_d = ST_SHIFT_WR;
        end else begin
          state_d = more_work_w ? ST_LCG_LO : ST_IDLE;
        end
      end
      ST_SHIFT_WR: state_d = ST_SHIFT_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, pool port, input ready
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    ram_we       = 1'b0;
    ram_waddr    = fill_q[AW-1:0];
    ram_wdata    = fill_q + CNT_W'(1);
    ram_raddr    = idx_q;
    item_i.ready = (state_q == ST_IDLE);
    case (state_q)
      ST_SEED_DIV, ST_LCG_HDIV: begin
        mul_a = OPND_W'(hi_q);
        mul_b = DEC_RECIP;
      end
      ST_SEED_REM, ST_LCG_CMUL, ST_LCG_HMUL: begin
        mul_a = OPND_W'(quot_w);
        mul_b = OPND_W'(DEC_SPLIT);
      end
      ST_FILL: begin
        ram_we = (fill_q != rem_q);
      end
      ST_LCG_LO, ST_LCG_DONE: begin
        mul_a = OPND_W'(sl_q);
        mul_b = OPND_W'(LCG_MULT_LO);
      end
      ST_LCG_HI: begin
        mul_a = OPND_W'(sh_q);
        mul_b = OPND_W'(LCG_MULT_LO);
      end
      ST_LCG_MID: begin
        mul_a = OPND_W'(sl_q);
        mul_b = OPND_W'(LCG_MULT_HI);
      end
      ST_LCG_CDIV: begin
        mul_a = OPND_W'(lo_q);
        mul_b = DEC_RECIP;
      end
      ST_PICK_MUL: begin
        mul_a = OPND_W'(sh_q);
        mul_b = OPND_W'(rem_q);
      end
      ST_PICK_DIV: begin
        mul_a = OPND_W'(mul_q[PickW-1:0]);
        mul_b = DEC_RECIP;
      end
      ST_PICK_RD: begin
        ram_raddr = quot_w[AW-1:0];
      end
      ST_SHIFT_RD: begin
        ram_raddr = ptr_q[AW-1:0];
      end
      ST_SHIFT_WR: begin
        // Move the entry read last cycle one place down.
        ram_we    = 1'b1;
        ram_waddr = ptr_prev_w[AW-1:0];
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  // Datapath updates
  always_comb begin
    sh_d         = sh_q;
    sl_d         = sl_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    rem_d        = rem_q;
    picks_left_d = picks_left_q;
    disc_d       = disc_q;
    fill_d       = fill_q;
    ptr_d        = ptr_q;
    idx_d        = idx_q;
    res_valid_d  = res_valid_q && !result_o.ready;
    res_num_d    = res_num_q;
    res_last_d   = res_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          if (item_i.op == OP_SEED) begin
            hi_d = item_i.seed_value;
          end else begin
            rem_d        = size_w;
            picks_left_d = picks_w;
            disc_d       = disc_steps_q;
            fill_d       = '0;
          end
        end
      end
      ST_SEED_REM: sh_d = quot_w;
      ST_SEED_LO:  sl_d = hi_q[HALF_W-1:0] - mul_q[HALF_W-1:0];
      ST_FILL: begin
        if (fill_q != rem_q) begin
          fill_d = fill_q + CNT_W'(1);
        end
      end
      ST_LCG_HI:   lo_d = mul_q[SEED_W-1:0] + SEED_W'(1);
      ST_LCG_MID:  hi_d = mul_q[SEED_W-1:0];
      ST_LCG_CDIV: hi_d = hi_q + mul_q[SEED_W-1:0];
      ST_LCG_CMUL: hi_d = hi_q + SEED_W'(quot_w);
      ST_LCG_HDIV: sl_d = lo_q[HALF_W-1:0] - mul_q[HALF_W-1:0];
      ST_LCG_DONE: begin
        sh_d = hi_q[HALF_W-1:0] - mul_q[HALF_W-1:0];
        if (picks_left_q == '0) begin
          disc_d = disc_q - DISC_W'(1);
        end
      end
      ST_PICK_RD: idx_d = quot_w[AW-1:0];
      ST_PICK_EMIT: begin
        if (slot_free_w) begin
          res_valid_d  = 1'b1;
          res_num_d    = ram_rdata;
          res_last_d   = (picks_left_q == CNT_W'(1));
          picks_left_d = picks_left_q - CNT_W'(1);
          ptr_d        = CNT_W'(idx_q) + CNT_W'(1);
        end
      end
      ST_SHIFT_RD: begin
        if (ptr_q >= rem_q) begin
          rem_d = rem_q - CNT_W'(1);
        end
      end
      ST_SHIFT_WR: ptr_d = ptr_q + CNT_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pool_size_q  <= POOL_SIZE_RST;
      pick_count_q <= PICK_COUNT_RST;
      disc_steps_q <= DISCARD_RST;
      sh_q         <= '0;
      sl_q         <= '0;
      rem_q        <= '0;
      picks_left_q <= '0;
      disc_q       <= '0;
      fill_q       <= '0;
      ptr_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pool_size_q  <= pool_size_d;
      pick_count_q <= pick_count_d;
      disc_steps_q <= disc_steps_d;
      sh_q         <= sh_d;
      sl_q         <= sl_d;
      rem_q        <= rem_d;
      picks_left_q <= picks_left_d;
      disc_q       <= disc_d;
      fill_q       <= fill_d;
      ptr_q        <= ptr_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q      <= mul_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    idx_q      <= idx_d;
    res_num_q  <= res_num_d;
    res_last_q <= res_last_d;
  end

  `ASSERT_ALWAYS(a_pick_in_pool, clk_i, rst_ni, (state_q != ST_PICK_RD) || (quot_w < HALF_W'(rem_q)), "pick index beyond pool")
  `ASSERT_NEXT(a_state_decimal, clk_i, rst_ni, state_q == ST_LCG_DONE, (sh_q < HALF_W'(DEC_SPLIT)) && (sl_q < HALF_W'(DEC_SPLIT)), "generator halves not decimal")
  `ASSERT_NEXT(a_last_flag, clk_i, rst_ni, emit_w, res_last_q == (picks_left_q == '0), "last flag out of step with pick count")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// -----------------------------------------------------------------------------
// LCG draw core testbench
// Drives seed loads and draw requests through the valid/ready channels. It
// also sweeps pool size, pick count and discard steps across their extremes.
// Every drawn number and last flag is checked against a cycle-free model of
// the decimal generator and the pool.
// -----------------------------------------------------------------------------
module testbench;
  import lcgswr_pkg::*;

  localparam int STALL_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [SEED_W-1:0] SEED_DEC_MAX  = 27'd99999999;
  localparam logic [SEED_W-1:0] SEED_DEC_WRAP = 27'd100000000;
  localparam logic [SEED_W-1:0] SEED_ALL_ONES = '1;

  typedef struct packed {
    logic [CNT_W-1:0] number;
    logic             last;
  } pick_t;

  class draw_scoreboard;
    localparam int POOL_CAP = 64;
    localparam longint unsigned GEN_MOD   = 100000000;
    localparam longint unsigned GEN_MUL   = 31415821;
    localparam longint unsigned GEN_SPLIT = 10000;

    logic [CNT_W-1:0]  pool_size;
    logic [CNT_W-1:0]  pick_count;
    logic [DISC_W-1:0] discard_steps;
    longint unsigned   gen_state;
    pick_t             picks_q[$];
    int                errors;

    function new();
      pool_size     = POOL_SIZE_RST;
      pick_count    = PICK_COUNT_RST;
      discard_steps = DISCARD_RST;
      gen_state     = 0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_POOL_SIZE:  pool_size = data[CNT_W-1:0];
        REG_PICK_COUNT: pick_count = data[CNT_W-1:0];
        REG_DISCARD:    discard_steps = data[DISC_W-1:0];
        default: ;
      endcase
    endfunction

    function void advance();
      gen_state = (gen_state * GEN_MUL + 1) % GEN_MOD;
    endfunction

    function void note_item(logic op, logic [SEED_W-1:0] seed);
      logic [CNT_W-1:0] entries [POOL_CAP];
      longint unsigned  idx;
      int unsigned      size, count, left;
      pick_t            pick;
      if (op == OP_SEED) begin
        gen_state = 64'(seed);
        return;
      end
      size  = (32'(pool_size) > POOL_CAP) ? POOL_CAP : 32'(pool_size);
      count = (32'(pick_count) > size) ? size : 32'(pick_count);
      for (int i = 0; i < size; i++) entries[i] = CNT_W'(i + 1);
      left = size;
      for (int k = 0; k < count; k++) begin
        advance();
        idx = ((gen_state / GEN_SPLIT) * 64'(left)) / GEN_SPLIT;
        pick.number = entries[idx];
        pick.last   = (k + 1 == count);
        picks_q.push_back(pick);
        // close the gap left by the drawn entry
        for (int i = int'(idx); i + 1 < left; i++) entries[i] = entries[i + 1];
        left--;
      end
      for (int k = 0; k < discard_steps; k++) advance();
    endfunction

    function void check_pick(logic [CNT_W-1:0] number, logic last);
      pick_t want;
      if (picks_q.size() == 0) begin
        errors++;
        $display("%0t: stray pick: expected none, actual number %0d last %0b",
                 $time, number, last);
        return;
      end
      want = picks_q.pop_front();
      if (number !== want.number) begin
        errors++;
        $display("%0t: picked_number mismatch: expected %0d, actual %0d",
                 $time, want.number, number);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_pick mismatch: expected %0b, actual %0b",
                 $time, want.last, last);
      end
    endfunction

    function int pending();
      return picks_q.size();
    endfunction

    function void flag_leftovers();
      if (picks_q.size() != 0) begin
        errors++;
        $display("%0t: %0d picks never arrived: expected number %0d, actual none",
                 $time, picks_q.size(), picks_q[0].number);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  lcgswr_item_if   req_if();
  lcgswr_result_if res_if();

  draw_scoreboard sb = new();
  int             src_idle_pct;
  int             snk_idle_pct;
  int             hold_req = 0;
  int             hold_left = 0;
  int             stall_cycles = 0;

  lcg_sample_without_replacement_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (req_if.sink),
    .result_o    (res_if.source)
  );

  always #1 clk_i = ~clk_i;

  // Result sink: random stalls, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        sb.check_pick(res_if.picked_number, res_if.last_pick);
      end
      if ((res_if.valid && res_if.ready) || (req_if.valid && req_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("lcg_sample_without_replacement_core test failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic op, logic [SEED_W-1:0] seed);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.seed_value <= seed;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_item(op, seed);
  endtask

  task automatic send_draws(int count);
    repeat (count) send_item(OP_DRAW, SEED_W'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Ready returns only once the discard steps are through.
  task automatic wait_idle();
    wait_drained();
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
  endtask

  task automatic configure(int pool, int picks, int disc, logic junk_high);
    logic [CFG_DATA_W-1:0] hi;
    wait_idle();
    hi = junk_high ? CFG_DATA_W'($urandom) : '0;
    write_reg(REG_POOL_SIZE, {hi[CFG_DATA_W-1:CNT_W], CNT_W'(pool)});
    write_reg(REG_PICK_COUNT, {hi[CFG_DATA_W-1:CNT_W], CNT_W'(picks)});
    write_reg(REG_DISCARD, CFG_DATA_W'(disc));
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(int count);
    logic              op;
    logic [SEED_W-1:0] seed;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      op = ($urandom_range(99) < 15) ? OP_SEED : OP_DRAW;
      if (op == OP_SEED && $urandom_range(1) == 1) begin
        seed = SEED_W'($urandom_range(0, 99999999));
      end else begin
        seed = SEED_W'($urandom);
      end
      send_item(op, seed);
    end
  endtask

  initial begin : main
    int pool, picks, disc, count, r;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_POOL_SIZE;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.op         = OP_DRAW;
    req_if.seed_value = '0;
    res_if.ready      = 1'b0;
    src_idle_pct      = 17;
    snk_idle_pct      = 77;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, generator starting from zero
    send_draws(1);
    send_item(OP_SEED, SEED_ALL_ONES);
    send_draws(1);
    send_item(OP_SEED, SEED_DEC_WRAP);
    send_draws(1);

    configure(1, 1, 0, 1'b0);
    send_item(OP_SEED, '0);
    send_draws(1);
    send_item(OP_SEED, SEED_DEC_MAX);
    send_draws(1);

    configure(64, 64, 0, 1'b0);
    send_draws(2);
    // pool and picks both above the pool limit
    configure(127, 127, 1, 1'b0);
    send_draws(1);
    // empty pool: discard steps only
    configure(0, 5, 3, 1'b0);
    send_draws(2);
    configure(10, 0, 2, 1'b0);
    send_draws(1);
    configure(5, 9, 4, 1'b1);
    send_item(OP_SEED, 27'd12345678);
    send_draws(2);
    configure(3, 2, 65535, 1'b0);
    send_draws(1);
    configure(64, 1, 0, 1'b1);
    send_draws(2);

    for (int m = 0; m < 3; m++) begin
      src_idle_pct = (m == 0) ? 17 : (m == 1) ? 77 : 0;
      snk_idle_pct = (m == 0) ? 77 : (m == 1) ? 17 : 0;
      for (int p = 0; p < 4; p++) begin
        count = (p < 2) ? 22 : 21;
        if (m == 0 && p == 0) begin
          // back up the result path so the core stops taking requests
          configure(12, 12, 5, 1'b0);
          hold_req = HOLD_CYCLES;
        end else begin
          r     = $urandom_range(99);
          pool  = (r < 75) ? $urandom_range(1, 16) : (r < 92) ? $urandom_range(17, 127) : 0;
          picks = ($urandom_range(99) < 85) ? $urandom_range(0, 18) : $urandom_range(19, 127);
          disc  = ($urandom_range(99) < 80) ? $urandom_range(0, 40) : $urandom_range(41, 300);
          configure(pool, picks, disc, logic'($urandom_range(1)));
        end
        send_random(count);
      end
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("lcg_sample_without_replacement_core test passed");
    end else begin
      $display("lcg_sample_without_replacement_core test failed");
    end
    $finish;
  end

endmodule
